[hdl/i2cmbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types, codes and phase timing table shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   // Command codes carried by a request transaction
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // Reset value of the acknowledge poll limit
   localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

   // Line sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST_A    = 5'd1,
      PH_ST_B    = 5'd2,
      PH_ST_C    = 5'd3,
      PH_SP_A    = 5'd4,
      PH_SP_B    = 5'd5,
      PH_WB_SET  = 5'd6,
      PH_WB_HIGH = 5'd7,
      PH_WB_LOW  = 5'd8,
      PH_WA_REL  = 5'd9,
      PH_WA_HIGH = 5'd10,
      PH_WA_POLL = 5'd11,
      PH_WA_END  = 5'd12,
      PH_RB_LOW  = 5'd13,
      PH_RB_HIGH = 5'd14,
      PH_AK_LOW  = 5'd15,
      PH_AK_HIGH = 5'd16,
      PH_AK_END  = 5'd17
   } phase_type;

   // Where the driven SDA level comes from in a phase
   typedef enum logic [1:0] {
      SDA_LOW  = 2'd0,
      SDA_HIGH = 2'd1,
      SDA_DATA = 2'd2,
      SDA_ACK  = 2'd3
   } sda_src_type;

   typedef struct packed {
      logic [2:0]  ticks;
      logic        scl;
      sda_src_type sda_src;
      logic        drive;
   } phase_info_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] write_byte;
      logic       ack_to_send;
      logic       sda_sample;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_error;
   } rsp_item_type;

   typedef struct packed {
      logic idle;
   } step_status_type;

   // Per-phase duration in ticks and line levels
   function automatic phase_info_type phase_info(phase_type p);
      phase_info_type r;
      case (p)
         PH_ST_A:    r = '{3'd4, 1'b1, SDA_HIGH, 1'b1};
         PH_ST_B:    r = '{3'd4, 1'b1, SDA_LOW,  1'b1};
         PH_ST_C:    r = '{3'd1, 1'b0, SDA_LOW,  1'b1};
         PH_SP_A:    r = '{3'd4, 1'b0, SDA_LOW,  1'b1};
         PH_SP_B:    r = '{3'd4, 1'b1, SDA_HIGH, 1'b1};
         PH_WB_SET:  r = '{3'd2, 1'b0, SDA_DATA, 1'b1};
         PH_WB_HIGH: r = '{3'd2, 1'b1, SDA_DATA, 1'b1};
         PH_WB_LOW:  r = '{3'd2, 1'b0, SDA_DATA, 1'b1};
         PH_WA_REL:  r = '{3'd1, 1'b0, SDA_HIGH, 1'b0};
         PH_WA_HIGH: r = '{3'd1, 1'b1, SDA_HIGH, 1'b0};
         PH_WA_POLL: r = '{3'd1, 1'b1, SDA_HIGH, 1'b0};
         PH_WA_END:  r = '{3'd1, 1'b0, SDA_HIGH, 1'b0};
         PH_RB_LOW:  r = '{3'd2, 1'b0, SDA_HIGH, 1'b0};
         PH_RB_HIGH: r = '{3'd1, 1'b1, SDA_HIGH, 1'b0};
         PH_AK_LOW:  r = '{3'd2, 1'b0, SDA_ACK,  1'b1};
         PH_AK_HIGH: r = '{3'd2, 1'b1, SDA_ACK,  1'b1};
         PH_AK_END:  r = '{3'd1, 1'b0, SDA_ACK,  1'b1};
         default:    r = '{3'd1, 1'b1, SDA_HIGH, 1'b1};
      endcase
      return r;
   endfunction

   // Tick counter load value on entering a phase; the poll phase counts up
   function automatic logic [7:0] enter_wait(phase_type p);
      phase_info_type info;
      info = phase_info(p);
      if (p == PH_WA_POLL) begin
         return 8'd0;
      end
      return {5'd0, info.ticks - 3'd1};
   endfunction

endpackage

[hdl/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Byte-level I2C master stepped by one tick transaction; start, stop, write
// byte with acknowledge poll, read byte with ACK/NACK.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid/req_ready   | command, write_byte, ack, sda
//  rsp_    | out       | rsp_valid/rsp_ready   | scl, sda, drive, status, byte
//  csr_    | in        | csr_valid/csr_ready   | ack_wait_limit (8 bits)
//
//  One transaction per clock while results are taken; a request is held in the
//  input register, then its result in the result register.
//  The line sequencer state updates once per processed transaction.
//  Reset: phase idle, SCL and SDA high, ack_wait_limit 250.
//  A stalled result holds the sequencer; csr writes are always taken.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_write_byte,
   input  logic       req_ack_to_send,
   input  logic       req_sda_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_sda_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_ack_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_ack_wait_limit
);

   i2cmbe_pkg::req_item_type    req_item;
   i2cmbe_pkg::req_item_type    held_item;
   i2cmbe_pkg::rsp_item_type    step_result;
   i2cmbe_pkg::rsp_item_type    rsp_item;
   i2cmbe_pkg::step_status_type step_status;
   logic                        held_valid;
   logic                        out_can_load;
   logic                        step_fire;

   assign req_item.command     = req_command;
   assign req_item.write_byte  = req_write_byte;
   assign req_item.ack_to_send = req_ack_to_send;
   assign req_item.sda_sample  = req_sda_sample;

   assign csr_ready = 1'b1;

   // Process a tick when one is held and the result slot is free
   assign step_fire = held_valid && out_can_load;

   i2cmbe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (step_fire),
      .item_valid (held_valid),
      .item       (held_item)
   );

   i2cmbe_step u_step (
      .clock       (clock),
      .reset       (reset),
      .step_fire   (step_fire),
      .req_item    (held_item),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_ack_wait_limit),
      .rsp_item    (step_result),
      .step_status (step_status)
   );

   i2cmbe_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step_fire),
      .result    (step_result),
      .can_load  (out_can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_scl_level = rsp_item.scl_level;
   assign rsp_sda_level = rsp_item.sda_level;
   assign rsp_sda_drive = rsp_item.sda_drive;
   assign rsp_busy_res  = rsp_item.busy_res;
   assign rsp_done_res  = rsp_item.done_res;
   assign rsp_read_byte = rsp_item.read_byte;
   assign rsp_ack_error = rsp_item.ack_error;

   // A finishing tick leaves the sequencer idle
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_result.done_res |=> step_status.idle)
      else $error("sequencer not idle after done");

   // Busy and done never show together
   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_busy_res && rsp_done_res))
      else $error("busy and done both set");

   // Released SDA always reads high
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> rsp_sda_level)
      else $error("released SDA reported low");

   // An idle sequencer drives both lines
   a_idle_drives: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_status.idle && (held_item.command == i2cmbe_pkg::CMD_NONE)
      |=> rsp_sda_drive && !rsp_busy_res && !rsp_done_res)
      else $error("idle tick reported activity");

endmodule

[hdl/i2cmbe_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_in_stage
// Input register for request transactions; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module i2cmbe_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2cmbe_pkg::req_item_type req_item,
   input  logic                     take,
   output logic                     item_valid,
   output i2cmbe_pkg::req_item_type item
);

   logic                     valid_ff;
   logic                     valid_in;
   i2cmbe_pkg::req_item_type item_ff;

   // Accept when empty or draining this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/i2cmbe_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_step
// Line sequencer: takes one tick item, drives SCL/SDA for the current phase
// and advances the phase, shift register and acknowledge poll counter.
// ----------------------------------------------------------------------------
module i2cmbe_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_fire,
   input  i2cmbe_pkg::req_item_type    req_item,
   input  logic                        csr_write,
   input  logic [7:0]                  csr_data,
   output i2cmbe_pkg::rsp_item_type    rsp_item,
   output i2cmbe_pkg::step_status_type step_status
);

   i2cmbe_pkg::phase_type phase_ff, phase_in;
   logic [7:0]            wait_count_ff, wait_count_in;
   logic [3:0]            bit_index_ff, bit_index_in;
   logic [7:0]            shift_data_ff, shift_data_in;
   logic                  ack_choice_ff, ack_choice_in;
   logic                  error_flag_ff, error_flag_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic [7:0]            last_read_ff, last_read_in;
   logic [7:0]            ack_limit_ff;

   i2cmbe_pkg::phase_type      cur_phase;
   logic [7:0]                 cur_wait;
   logic [3:0]                 cur_bit;
   logic [7:0]                 cur_shift;
   logic                       cur_ack;
   logic [3:0]                 bit_next;
   logic [7:0]                 read_shift;
   logic                       lvl;
   i2cmbe_pkg::phase_info_type info;

   always_comb begin
      // Launch a command when idle
      cur_phase = phase_ff;
      cur_wait  = wait_count_ff;
      cur_bit   = bit_index_ff;
      cur_shift = shift_data_ff;
      cur_ack   = ack_choice_ff;
      if (phase_ff == i2cmbe_pkg::PH_IDLE) begin
         case (req_item.command)
            i2cmbe_pkg::CMD_START: begin
               cur_phase = i2cmbe_pkg::PH_ST_A;
               cur_wait  = i2cmbe_pkg::enter_wait(i2cmbe_pkg::PH_ST_A);
            end
            i2cmbe_pkg::CMD_STOP: begin
               cur_phase = i2cmbe_pkg::PH_SP_A;
               cur_wait  = i2cmbe_pkg::enter_wait(i2cmbe_pkg::PH_SP_A);
            end
            i2cmbe_pkg::CMD_WRITE: begin
               cur_phase = i2cmbe_pkg::PH_WB_SET;
               cur_wait  = i2cmbe_pkg::enter_wait(i2cmbe_pkg::PH_WB_SET);
               cur_shift = req_item.write_byte;
               cur_bit   = 4'd0;
            end
            i2cmbe_pkg::CMD_READ: begin
               cur_phase = i2cmbe_pkg::PH_RB_LOW;
               cur_wait  = i2cmbe_pkg::enter_wait(i2cmbe_pkg::PH_RB_LOW);
               cur_ack   = req_item.ack_to_send;
               cur_shift = 8'd0;
               cur_bit   = 4'd0;
            end
            default: begin
            end
         endcase
      end

      // Resolve line levels for the phase in force this tick
      info = i2cmbe_pkg::phase_info(cur_phase);
      case (info.sda_src)
         i2cmbe_pkg::SDA_LOW:  lvl = 1'b0;
         i2cmbe_pkg::SDA_HIGH: lvl = 1'b1;
         i2cmbe_pkg::SDA_DATA: lvl = cur_shift[7];
         i2cmbe_pkg::SDA_ACK:  lvl = !cur_ack;
         default:              lvl = 1'b1;
      endcase

      bit_next   = cur_bit + 4'd1;
      read_shift = {cur_shift[6:0], req_item.sda_sample};

      phase_in      = cur_phase;
      wait_count_in = cur_wait;
      bit_index_in  = cur_bit;
      shift_data_in = cur_shift;
      ack_choice_in = cur_ack;
      error_flag_in = error_flag_ff;
      last_read_in  = last_read_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;

      if (cur_phase != i2cmbe_pkg::PH_IDLE) begin
         scl_in = info.scl;
         sda_in = lvl;

         // Advance the phase
         if (cur_phase == i2cmbe_pkg::PH_WA_POLL) begin
            if (!req_item.sda_sample) begin
               error_flag_in = 1'b0;
               phase_in      = i2cmbe_pkg::PH_WA_END;
               wait_count_in = i2cmbe_pkg::enter_wait(i2cmbe_pkg::PH_WA_END);
            end else if (cur_wait >= ack_limit_ff) begin
               error_flag_in = 1'b1;
               phase_in      = i2cmbe_pkg::PH_SP_A;
               wait_count_in = i2cmbe_pkg::enter_wait(i2cmbe_pkg::PH_SP_A);
            end else begin
               wait_count_in = cur_wait + 8'd1;
            end
         end else if (cur_wait != 8'd0) begin
            wait_count_in = cur_wait - 8'd1;
         end else begin
            case (cur_phase)
               i2cmbe_pkg::PH_ST_A:    phase_in = i2cmbe_pkg::PH_ST_B;
               i2cmbe_pkg::PH_ST_B:    phase_in = i2cmbe_pkg::PH_ST_C;
               i2cmbe_pkg::PH_SP_A:    phase_in = i2cmbe_pkg::PH_SP_B;
               i2cmbe_pkg::PH_WB_SET:  phase_in = i2cmbe_pkg::PH_WB_HIGH;
               i2cmbe_pkg::PH_WB_HIGH: phase_in = i2cmbe_pkg::PH_WB_LOW;
               i2cmbe_pkg::PH_WB_LOW: begin
                  shift_data_in = {cur_shift[6:0], 1'b0};
                  bit_index_in  = bit_next;
                  phase_in = (bit_next >= 4'd8) ? i2cmbe_pkg::PH_WA_REL
                                                : i2cmbe_pkg::PH_WB_SET;
               end
               i2cmbe_pkg::PH_WA_REL:  phase_in = i2cmbe_pkg::PH_WA_HIGH;
               i2cmbe_pkg::PH_WA_HIGH: phase_in = i2cmbe_pkg::PH_WA_POLL;
               i2cmbe_pkg::PH_RB_LOW:  phase_in = i2cmbe_pkg::PH_RB_HIGH;
               i2cmbe_pkg::PH_RB_HIGH: begin
                  shift_data_in = read_shift;
                  bit_index_in  = bit_next;
                  if (bit_next >= 4'd8) begin
                     last_read_in = read_shift;
                     phase_in     = i2cmbe_pkg::PH_AK_LOW;
                  end else begin
                     phase_in = i2cmbe_pkg::PH_RB_LOW;
                  end
               end
               i2cmbe_pkg::PH_AK_LOW:  phase_in = i2cmbe_pkg::PH_AK_HIGH;
               i2cmbe_pkg::PH_AK_HIGH: phase_in = i2cmbe_pkg::PH_AK_END;
               default:                phase_in = i2cmbe_pkg::PH_IDLE;
            endcase
            wait_count_in = i2cmbe_pkg::enter_wait(phase_in);
         end
      end
   end

   // Drive the result fields for this tick
   always_comb begin
      rsp_item.scl_level = scl_ff;
      rsp_item.sda_level = sda_ff;
      rsp_item.sda_drive = 1'b1;
      rsp_item.busy_res  = 1'b0;
      rsp_item.done_res  = 1'b0;
      if (cur_phase != i2cmbe_pkg::PH_IDLE) begin
         rsp_item.scl_level = info.scl;
         rsp_item.sda_level = lvl;
         rsp_item.sda_drive = info.drive;
         rsp_item.busy_res  = (phase_in != i2cmbe_pkg::PH_IDLE);
         rsp_item.done_res  = (phase_in == i2cmbe_pkg::PH_IDLE);
      end
      rsp_item.read_byte = last_read_in;
      rsp_item.ack_error = error_flag_in;
   end

   // Hold state between ticks; advance on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cmbe_pkg::PH_IDLE;
         wait_count_ff <= 8'd0;
         bit_index_ff  <= 4'd0;
         shift_data_ff <= 8'd0;
         ack_choice_ff <= 1'b0;
         error_flag_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         last_read_ff  <= 8'd0;
         ack_limit_ff  <= i2cmbe_pkg::ACK_LIMIT_RESET;
      end else begin
         if (csr_write) begin
            ack_limit_ff <= csr_data;
         end
         if (step_fire) begin
            phase_ff      <= phase_in;
            wait_count_ff <= wait_count_in;
            bit_index_ff  <= bit_index_in;
            shift_data_ff <= shift_data_in;
            ack_choice_ff <= ack_choice_in;
            error_flag_ff <= error_flag_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            last_read_ff  <= last_read_in;
         end
      end
   end

   assign step_status.idle = (phase_ff == i2cmbe_pkg::PH_IDLE);

endmodule

[hdl/i2cmbe_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_out_stage
// Result register; loads a new result in the cycle the old one is taken.
// ----------------------------------------------------------------------------
module i2cmbe_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  i2cmbe_pkg::rsp_item_type result,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output i2cmbe_pkg::rsp_item_type rsp_item
);

   logic                     valid_ff;
   logic                     valid_in;
   i2cmbe_pkg::rsp_item_type item_ff;

   // Free when empty or being taken this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
